@@ hdl/rbfh_pkg.sv @@
// Shared types, constants and helper functions for the ray and box face hit unit.
package rbfh_pkg;

    localparam int unsigned CoordW     = 32;
    localparam int unsigned FracBits   = 16;
    localparam int unsigned NumW       = 50;
    localparam int unsigned DivStages  = 8;
    localparam int unsigned DivStepBits = CoordW / DivStages;
    localparam int unsigned FifoDepth  = 4;
    localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
    localparam int unsigned FifoCntW   = $clog2(FifoDepth + 1);

    localparam logic [30:0] HalfExtentReset = 31'd32768;
    localparam logic signed [CoordW-1:0] CoordMax = 32'sh7fff_ffff;
    localparam logic signed [CoordW-1:0] CoordMin = 32'sh8000_0000;

    typedef logic [2:0] face_t;
    localparam face_t FACE_FRONT  = 3'd0;
    localparam face_t FACE_BACK   = 3'd1;
    localparam face_t FACE_RIGHT  = 3'd2;
    localparam face_t FACE_LEFT   = 3'd3;
    localparam face_t FACE_TOP    = 3'd4;
    localparam face_t FACE_BOTTOM = 3'd5;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef struct packed {
        face_t                     face;
        logic                      last_face;
        logic                      skip;
        logic                      neg;
        axis_t                     axis;
        logic signed [CoordW:0]    plane;
        logic signed [CoordW-1:0]  oc0;
        logic signed [CoordW-1:0]  oc1;
        logic signed [CoordW-1:0]  dc0;
        logic signed [CoordW-1:0]  dc1;
    } job_t;

    typedef struct packed {
        logic                      hit;
        face_t                     face;
        logic signed [CoordW-1:0]  px;
        logic signed [CoordW-1:0]  py;
        logic signed [CoordW-1:0]  pz;
        logic                      last;
    } result_t;

    function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [48:0] v);
        if (v[48:CoordW-1] != {(50-CoordW){v[48]}})
        begin
            return v[48] ? CoordMin : CoordMax;
        end
        return v[CoordW-1:0];
    endfunction

endpackage

@@ hdl/rbfh_div.sv @@
// Pipelined restoring divider for the face parameter, with overflow flag.
module rbfh_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [49:0]           num,
    input  logic [31:0]           den,
    input  rbfh_pkg::job_t        in_job,
    output logic                  out_valid,
    output logic [31:0]           quo,
    output logic                  ovf,
    output rbfh_pkg::job_t        out_job
);
    import rbfh_pkg::*;

    typedef struct packed {
        logic [CoordW-1:0] rem;
        logic [CoordW-1:0] num_lo;
        logic [CoordW-1:0] quo;
        logic [CoordW-1:0] den;
        logic              ovf;
        job_t              job;
    } div_stage_t;

    div_stage_t             st_reg [0:DivStages];
    logic [DivStages:0]     vld_reg;

    function automatic div_stage_t div_step(input div_stage_t s);
        div_stage_t   cur;
        logic [CoordW:0] r2;
        logic         qb;
        cur = s;
        for (int i = 0; i < DivStepBits; i++)
        begin
            r2 = {cur.rem, cur.num_lo[CoordW-1]};
            cur.num_lo = {cur.num_lo[CoordW-2:0], 1'b0};
            qb = 1'b0;
            if (r2 >= {1'b0, cur.den})
            begin
                r2 = r2 - {1'b0, cur.den};
                qb = 1'b1;
            end
            cur.rem = r2[CoordW-1:0];
            cur.quo = {cur.quo[CoordW-2:0], qb};
        end
        return cur;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DivStages-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0].rem    <= {14'd0, num[49:CoordW]};
            st_reg[0].num_lo <= num[CoordW-1:0];
            st_reg[0].quo    <= '0;
            st_reg[0].den    <= den;
            st_reg[0].ovf    <= ({14'd0, num[49:CoordW]} >= den);
            st_reg[0].job    <= in_job;
            for (int k = 1; k <= DivStages; k++)
            begin
                st_reg[k] <= div_step(st_reg[k-1]);
            end
        end
    end

    assign out_valid = vld_reg[DivStages];
    assign quo       = st_reg[DivStages].quo;
    assign ovf       = st_reg[DivStages].ovf;
    assign out_job   = st_reg[DivStages].job;

endmodule

@@ hdl/ray_box_face_hits_unit.sv @@
// Top level: ray against a centered cube's six faces, one face per cycle unless held.
//
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | origin_x..z, dir_x..z (one ray per word)
//  out     | out_valid / out_stall| hit, face, point_x..z, last
//  cfg     | cfg_we               | cfg_wdata (half_extent)
//
// A ray becomes six face jobs, one per cycle unless held, into a 14-stage pipeline.
// The divider takes four quotient bits per stage over eight stages.
// Reset clears all valid bits and the output queue and loads half_extent to 0.5.
// A stall on the output holds the whole pipeline once the four-word queue nears full.
module ray_box_face_hits_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [30:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic [2:0]         face,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic               last
);
    import rbfh_pkg::*;

    logic [30:0]              half_reg;
    logic                     busy_reg;
    face_t                    face_reg;
    logic signed [CoordW-1:0] ox_reg, oy_reg, oz_reg, dx_reg, dy_reg, dz_reg;

    logic                     adv;
    logic                     accept;

    job_t                     iss_job;
    logic [NumW-1:0]          iss_num;
    logic [CoordW-1:0]        iss_den;
    logic signed [CoordW-1:0] o_a, d_a;
    logic signed [CoordW:0]   h_s;
    logic signed [33:0]       diff;
    logic [33:0]              absdiff;

    logic                     s0_vld_reg;
    job_t                     s0_job_reg;
    logic [NumW-1:0]          s0_num_reg;
    logic [CoordW-1:0]        s0_den_reg;

    logic                     dv_vld;
    logic [CoordW-1:0]        dv_quo;
    logic                     dv_ovf;
    job_t                     dv_job;

    logic                     t_vld_reg;
    logic signed [CoordW-1:0] t_reg, t_next;
    job_t                     t_job_reg;

    logic                     m_vld_reg;
    logic signed [63:0]       m0_reg, m1_reg;
    job_t                     m_job_reg;

    logic                     a_vld_reg;
    logic signed [CoordW-1:0] a0_reg, a1_reg;
    job_t                     a_job_reg;

    logic                     c_vld_reg;
    logic                     c_inside_reg, c_inside_next;
    result_t                  c_res_reg, c_res_next;
    logic                     c_lastf_reg;

    result_t                  pend_reg, pend_next;
    logic                     pend_vld_reg, pend_vld_next;

    result_t                  fifo_mem [0:FifoDepth-1];
    logic [FifoPtrW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [FifoCntW-1:0]      cnt_reg;
    result_t                  e0, e1, nohit;
    logic                     push0, push1, pop;

    assign adv      = (cnt_reg <= FifoCntW'(FifoDepth - 2));
    assign in_stall = !(!busy_reg || (adv && face_reg == FACE_BOTTOM));
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= HalfExtentReset;
            busy_reg <= 1'b0;
            face_reg <= FACE_FRONT;
        end
        else
        begin
            if (cfg_we)
            begin
                half_reg <= cfg_wdata;
            end
            if (accept)
            begin
                busy_reg <= 1'b1;
                face_reg <= FACE_FRONT;
            end
            else if (adv && busy_reg && face_reg == FACE_BOTTOM)
            begin
                busy_reg <= 1'b0;
            end
            else if (adv && busy_reg)
            begin
                face_reg <= face_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ox_reg <= origin_x;
            oy_reg <= origin_y;
            oz_reg <= origin_z;
            dx_reg <= dir_x;
            dy_reg <= dir_y;
            dz_reg <= dir_z;
        end
    end

    always_comb
    begin
        h_s = $signed({2'b00, half_reg});
        iss_job = '0;
        iss_job.face = face_reg;
        iss_job.last_face = (face_reg == FACE_BOTTOM);
        iss_job.plane = face_reg[0] ? -h_s : h_s;
        unique case (face_reg)
            FACE_FRONT, FACE_BACK:
            begin
                iss_job.axis = AXIS_Z;
                o_a = oz_reg;
                d_a = dz_reg;
                iss_job.oc0 = ox_reg;
                iss_job.oc1 = oy_reg;
                iss_job.dc0 = dx_reg;
                iss_job.dc1 = dy_reg;
            end
            FACE_RIGHT, FACE_LEFT:
            begin
                iss_job.axis = AXIS_X;
                o_a = ox_reg;
                d_a = dx_reg;
                iss_job.oc0 = oy_reg;
                iss_job.oc1 = oz_reg;
                iss_job.dc0 = dy_reg;
                iss_job.dc1 = dz_reg;
            end
            default:
            begin
                iss_job.axis = AXIS_Y;
                o_a = oy_reg;
                d_a = dy_reg;
                iss_job.oc0 = ox_reg;
                iss_job.oc1 = oz_reg;
                iss_job.dc0 = dx_reg;
                iss_job.dc1 = dz_reg;
            end
        endcase
        diff = $signed({iss_job.plane[CoordW], iss_job.plane}) - $signed({{2{o_a[31]}}, o_a});
        absdiff = diff[33] ? 34'(-diff) : 34'(diff);
        iss_num = {absdiff, {FracBits{1'b0}}};
        iss_den = d_a[31] ? 32'(-d_a) : 32'(d_a);
        iss_job.neg = diff[33] ^ d_a[31];
        iss_job.skip = (d_a == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            t_vld_reg  <= 1'b0;
            m_vld_reg  <= 1'b0;
            a_vld_reg  <= 1'b0;
            c_vld_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg <= busy_reg;
            t_vld_reg  <= dv_vld;
            m_vld_reg  <= t_vld_reg;
            a_vld_reg  <= m_vld_reg;
            c_vld_reg  <= a_vld_reg;
        end
    end

    rbfh_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s0_vld_reg),
        .num       (s0_num_reg),
        .den       (s0_den_reg),
        .in_job    (s0_job_reg),
        .out_valid (dv_vld),
        .quo       (dv_quo),
        .ovf       (dv_ovf),
        .out_job   (dv_job)
    );

    always_comb
    begin
        if (!dv_job.neg)
        begin
            t_next = (dv_ovf || dv_quo[31]) ? CoordMax : $signed(dv_quo);
        end
        else
        begin
            t_next = (dv_ovf || dv_quo > 32'h8000_0000) ? CoordMin : $signed(32'(-dv_quo));
        end
    end

    always_comb
    begin
        logic signed [32:0] v0, v1;
        v0 = {a0_reg[31], a0_reg};
        v1 = {a1_reg[31], a1_reg};
        c_inside_next = !a_job_reg.skip
            && v0 >= -$signed({2'b00, half_reg}) && v0 <= $signed({2'b00, half_reg})
            && v1 >= -$signed({2'b00, half_reg}) && v1 <= $signed({2'b00, half_reg});
        c_res_next.hit  = 1'b1;
        c_res_next.face = a_job_reg.face;
        c_res_next.last = 1'b0;
        unique case (a_job_reg.axis)
            AXIS_X:
            begin
                c_res_next.px = a_job_reg.plane[31:0];
                c_res_next.py = a0_reg;
                c_res_next.pz = a1_reg;
            end
            AXIS_Y:
            begin
                c_res_next.px = a0_reg;
                c_res_next.py = a_job_reg.plane[31:0];
                c_res_next.pz = a1_reg;
            end
            default:
            begin
                c_res_next.px = a0_reg;
                c_res_next.py = a1_reg;
                c_res_next.pz = a_job_reg.plane[31:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_job_reg   <= iss_job;
            s0_num_reg   <= iss_num;
            s0_den_reg   <= iss_den;
            t_reg        <= t_next;
            t_job_reg    <= dv_job;
            m0_reg       <= t_job_reg.dc0 * t_reg;
            m1_reg       <= t_job_reg.dc1 * t_reg;
            m_job_reg    <= t_job_reg;
            a0_reg       <= sat_coord($signed({{17{m_job_reg.oc0[31]}}, m_job_reg.oc0})
                                      + $signed({m0_reg[63], m0_reg[63:FracBits]}));
            a1_reg       <= sat_coord($signed({{17{m_job_reg.oc1[31]}}, m_job_reg.oc1})
                                      + $signed({m1_reg[63], m1_reg[63:FracBits]}));
            a_job_reg    <= m_job_reg;
            c_inside_reg <= c_inside_next;
            c_res_reg    <= c_res_next;
            c_lastf_reg  <= a_job_reg.last_face;
        end
    end

    always_comb
    begin
        nohit = '0;
        nohit.last = 1'b1;
        e0 = pend_reg;
        e1 = c_res_reg;
        push0 = 1'b0;
        push1 = 1'b0;
        pend_next = pend_reg;
        pend_vld_next = pend_vld_reg;
        if (adv && c_vld_reg)
        begin
            if (c_inside_reg && pend_vld_reg)
            begin
                push0 = 1'b1;
            end
            if (c_inside_reg)
            begin
                pend_next = c_res_reg;
                pend_vld_next = 1'b1;
            end
            if (c_lastf_reg)
            begin
                pend_vld_next = 1'b0;
                if (push0)
                begin
                    push1 = 1'b1;
                    e1.last = 1'b1;
                end
                else
                begin
                    push0 = 1'b1;
                    if (c_inside_reg)
                    begin
                        e0 = c_res_reg;
                    end
                    else if (!pend_vld_reg)
                    begin
                        e0 = nohit;
                    end
                    e0.last = 1'b1;
                end
            end
        end
    end

    assign pop = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            pend_vld_reg <= pend_vld_next;
            wr_ptr_reg   <= wr_ptr_reg + FifoPtrW'(push0) + FifoPtrW'(push1);
            rd_ptr_reg   <= rd_ptr_reg + FifoPtrW'(pop);
            cnt_reg      <= cnt_reg + FifoCntW'(push0) + FifoCntW'(push1) - FifoCntW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (push0)
        begin
            fifo_mem[wr_ptr_reg] <= e0;
        end
        if (push1)
        begin
            fifo_mem[wr_ptr_reg + FifoPtrW'(1)] <= e1;
        end
    end

    assign out_valid = (cnt_reg != '0);
    assign hit       = fifo_mem[rd_ptr_reg].hit;
    assign face      = fifo_mem[rd_ptr_reg].face;
    assign point_x   = fifo_mem[rd_ptr_reg].px;
    assign point_y   = fifo_mem[rd_ptr_reg].py;
    assign point_z   = fifo_mem[rd_ptr_reg].pz;
    assign last      = fifo_mem[rd_ptr_reg].last;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FifoCntW'(FifoDepth))
        else $error("output queue overflow");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && face_reg != FACE_BOTTOM) |-> in_stall)
        else $error("new ray taken in the middle of a face sweep");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(c_vld_reg) && $stable(pend_vld_reg))
        else $error("pipeline tail moved while held");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && c_vld_reg && c_lastf_reg) |=> !pend_vld_reg)
        else $error("pending hit kept past the end of a ray");

endmodule

@@ sim/tb_ray_box_face_hits_unit.sv @@
// Self-checking testbench for the ray and box face hit unit.
module tb_ray_box_face_hits_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rbfh_pkg::*;

    localparam int WatchdogLimit = 3000;
    localparam int HoldCycles    = 300;
    localparam int DrainCycles   = 40;

    typedef struct {
        logic signed [31:0] ox, oy, oz, dx, dy, dz;
    } ray_t;

    typedef struct {
        ray_t    ray;
        int      n_typed;
        result_t typed[2];
    } ray_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [30:0]        cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
    logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               hit, last;
    logic [2:0]         face;
    logic signed [31:0] point_x, point_y, point_z;

    result_t     pending_hits[$];
    logic [30:0] half_extent_copy = HalfExtentReset;
    int          errors = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_req = 1'b0;
    int          quiet_cycles = 0;

    ray_box_face_hits_unit u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .face(face), .point_x(point_x), .point_y(point_y),
        .point_z(point_z), .last(last)
    );

    always #6 clk = ~clk;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic void expect_word(result_t res);
        pending_hits = {pending_hits, res};
    endfunction

    function automatic void predict_face_hits(ray_t r);
        longint  o[3], d[3], pt[3];
        longint  hh, plane, t;
        int      a, cnt;
        bit      ins;
        result_t res;
        o[0] = longint'(r.ox); o[1] = longint'(r.oy); o[2] = longint'(r.oz);
        d[0] = longint'(r.dx); d[1] = longint'(r.dy); d[2] = longint'(r.dz);
        hh = longint'(half_extent_copy);
        cnt = 0;
        for (int f = 0; f < 6; f++)
        begin
            a = (f < 2) ? 2 : ((f < 4) ? 0 : 1);
            if (d[a] == 0)
                continue;
            plane = (f % 2 == 0) ? hh : -hh;
            t = clamp32(((plane - o[a]) * 65536) / d[a]);
            ins = 1'b1;
            for (int c = 0; c < 3; c++)
            begin
                if (c == a)
                    pt[c] = plane;
                else
                    pt[c] = clamp32(o[c] + ((d[c] * t) >>> 16));
                if (pt[c] < -hh || pt[c] > hh)
                    ins = 1'b0;
            end
            if (ins)
            begin
                res.hit = 1'b1;
                res.face = face_t'(f);
                res.px = pt[0][31:0];
                res.py = pt[1][31:0];
                res.pz = pt[2][31:0];
                res.last = 1'b0;
                expect_word(res);
                cnt++;
            end
        end
        if (cnt == 0)
            expect_word('{1'b0, FACE_FRONT, 32'sd0, 32'sd0, 32'sd0, 1'b1});
        else
            pending_hits[pending_hits.size()-1].last = 1'b1;
    endfunction

    function automatic ray_t random_ray();
        ray_t   r;
        longint span, org[3], dv[3], tgt;
        if ($urandom_range(9) < 2)
        begin
            r.ox = $urandom; r.oy = $urandom; r.oz = $urandom;
            r.dx = $urandom; r.dy = $urandom; r.dz = $urandom;
            return r;
        end
        span = (half_extent_copy < 4) ? 64'sd4 : longint'(half_extent_copy);
        for (int c = 0; c < 3; c++)
        begin
            org[c] = clamp32(longint'($urandom_range(6000)) * span / 1000 - 3 * span);
            tgt = longint'($urandom_range(2000)) * span / 1000 - span;
            dv[c] = ($urandom_range(7) == 0) ? 64'sd0 : clamp32(tgt - org[c]);
        end
        r.ox = 32'(org[0]); r.oy = 32'(org[1]); r.oz = 32'(org[2]);
        r.dx = 32'(dv[0]); r.dy = 32'(dv[1]); r.dz = 32'(dv[2]);
        return r;
    endfunction

    task automatic send_ray(ray_t r, int n_typed, result_t typed[2]);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        origin_x = r.ox; origin_y = r.oy; origin_z = r.oz;
        dir_x = r.dx; dir_y = r.dy; dir_z = r.dz;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        if (n_typed == 0)
            predict_face_hits(r);
        else
            for (int i = 0; i < n_typed; i++)
                expect_word(typed[i]);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_half_extent(logic [30:0] value);
        while (pending_hits.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
        cfg_wdata = value;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        half_extent_copy = value;
    endtask

    always @(negedge clk)
    begin : receiver
        static int  hold_left = 0;
        static bit  hold_done = 1'b0;
        if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall = 1'b1;
        end
        else
            out_stall = ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin : check_outputs
        result_t e;
        if (out_valid && !out_stall)
        begin
            if (pending_hits.size() == 0)
            begin
                $error("unexpected word: face %0d", face);
                errors++;
            end
            else
            begin
                e = pending_hits.pop_front();
                if (hit !== e.hit)
                begin
                    $error("hit: expected %0d, got %0d", e.hit, hit);
                    errors++;
                end
                if (face !== e.face)
                begin
                    $error("face: expected %0d, got %0d", e.face, face);
                    errors++;
                end
                if (point_x !== e.px)
                begin
                    $error("point_x: expected %0d, got %0d", e.px, point_x);
                    errors++;
                end
                if (point_y !== e.py)
                begin
                    $error("point_y: expected %0d, got %0d", e.py, point_y);
                    errors++;
                end
                if (point_z !== e.pz)
                begin
                    $error("point_z: expected %0d, got %0d", e.pz, point_z);
                    errors++;
                end
                if (last !== e.last)
                begin
                    $error("last: expected %0d, got %0d", e.last, last);
                    errors++;
                end
            end
        end
        if ((out_valid && !out_stall) || (in_valid && !in_stall) || cfg_we || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("tb_ray_box_face_hits_unit: errors");
            $finish;
        end
    end

    localparam int One = 65536;
    localparam int Half = 32768;

    ray_row_t directed[11] = '{
        '{'{0, 0, 0, 0, 0, 0}, 1,
          '{'{1'b0, FACE_FRONT, 0, 0, 0, 1'b1}, '{1'b0, FACE_FRONT, 0, 0, 0, 1'b0}}},
        '{'{0, 0, 0, 0, 0, One}, 2,
          '{'{1'b1, FACE_FRONT, 0, 0, Half, 1'b0}, '{1'b1, FACE_BACK, 0, 0, -Half, 1'b1}}},
        '{'{0, 0, 0, One, 0, 0}, 2,
          '{'{1'b1, FACE_RIGHT, Half, 0, 0, 1'b0}, '{1'b1, FACE_LEFT, -Half, 0, 0, 1'b1}}},
        '{'{0, 0, 0, 0, One, 0}, 2,
          '{'{1'b1, FACE_TOP, 0, Half, 0, 1'b0}, '{1'b1, FACE_BOTTOM, 0, -Half, 0, 1'b1}}},
        '{'{5 * One, 5 * One, 0, 0, 0, One}, 1,
          '{'{1'b0, FACE_FRONT, 0, 0, 0, 1'b1}, '{1'b0, FACE_FRONT, 0, 0, 0, 1'b0}}},
        '{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
            32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff}, 0, '{default: '0}},
        '{'{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
            32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 0, '{default: '0}},
        '{'{0, 0, -2 * One, 0, 0, 1}, 0, '{default: '0}},
        '{'{0, 0, 0, One, One, One}, 0, '{default: '0}},
        '{'{0, 0, 0, -1, 3, -7}, 0, '{default: '0}},
        '{'{-One, Half, 3 * One, Half, -Half, -One}, 0, '{default: '0}}
    };

    logic [30:0] settings[5] = '{31'd0, 31'h7fff_ffff, 31'd65536, 31'd0, 31'd1000};

    initial
    begin : stimulus
        result_t none[2];
        none = '{default: '0};
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (directed[i])
            send_ray(directed[i].ray, directed[i].n_typed, directed[i].typed);
        for (int p = 0; p < 5; p++)
        begin
            write_half_extent((p == 3) ? 31'($urandom) : settings[p]);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 82; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            if (p == 4)
                hold_req = 1'b1;
            repeat (30) send_ray(random_ray(), 0, none);
        end
        while (pending_hits.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
        if (errors == 0)
            $display("tb_ray_box_face_hits_unit: clean");
        else
            $display("tb_ray_box_face_hits_unit: errors");
        $finish;
    end
endmodule

@@ files.f @@
hdl/rbfh_pkg.sv
hdl/rbfh_div.sv
hdl/ray_box_face_hits_unit.sv
sim/tb_ray_box_face_hits_unit.sv
